@@ design/nq_pkg.sv @@
// Shared constants, types and helpers for the N-queens solution enumerator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package nq_pkg;

  localparam int MAX_QUEENS = 16;
  localparam int ROW_W      = 4;
  localparam int SIZE_W     = 5;
  localparam int LVL_W      = 4;
  localparam int CNT_W      = 24;
  localparam int PLACE_W    = MAX_QUEENS * ROW_W;

  localparam logic [SIZE_W-1:0] BOARD_RESET = SIZE_W'(10);
  localparam logic [CNT_W-1:0]  COUNT_MAX   = {CNT_W{1'b1}};

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [LVL_W-1:0]  lvl_t;

  typedef struct packed {
    logic               found;
    logic [PLACE_W-1:0] placement;
    logic [CNT_W-1:0]   count;
  } res_t;

  // Board size as used by the search: zero acts as one, large values clamp.
  function automatic size_t eff_size(input size_t b);
    size_t r;
    r = b;
    if (b == '0) begin
      r = SIZE_W'(1);
    end else if (b > SIZE_W'(MAX_QUEENS)) begin
      r = SIZE_W'(MAX_QUEENS);
    end
    return r;
  endfunction

endpackage

@@ design/nq_attack_unit.sv @@
// Shared conflict comparator: tests one earlier queen against the candidate.
// Depends on nq_pkg.
`timescale 1ns / 1ps
module nq_attack_unit import nq_pkg::*; (
  input  lvl_t lvl,
  input  lvl_t col,
  input  row_t cand,
  input  row_t other,
  output logic hit
);

  logic [ROW_W:0] col_gap;
  logic [ROW_W:0] cand_x;
  logic [ROW_W:0] other_x;

  // The earlier column is always below the current one, so the gap is positive.
  assign col_gap = {1'b0, lvl - col};
  assign cand_x  = {1'b0, cand};
  assign other_x = {1'b0, other};

  assign hit = (other_x == cand_x) ||
               (other_x + col_gap == cand_x) ||
               (cand_x + col_gap == other_x);

endmodule

@@ design/nq_search_seq.sv @@
// Backtracking sequencer with the stored queen rows and the solution count.
// Depends on nq_pkg and nq_attack_unit.
`timescale 1ns / 1ps
module nq_search_seq import nq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  go,
  input  logic  restart,
  input  size_t n,
  output logic  busy,
  output res_t  res,
  output logic  res_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_TEST  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state;
  row_t             rows [MAX_QUEENS];
  lvl_t             lvl;
  lvl_t             col;
  logic [SIZE_W-1:0] row;
  logic             adv;
  logic             sdone;
  logic [CNT_W-1:0] count;

  lvl_t             n_m1;
  lvl_t             rd_addr;
  row_t             rd;
  logic             hit;
  logic [CNT_W-1:0] count_inc;
  logic [PLACE_W-1:0] packed_rows;
  logic             last_col;
  logic [SIZE_W-1:0] n_dec;

  assign n_dec     = n - SIZE_W'(1);
  assign n_m1      = n_dec[LVL_W-1:0];
  assign rd_addr   = (state == S_CHECK) ? col : lvl;
  assign rd        = rows[rd_addr];
  assign count_inc = (count == COUNT_MAX) ? count : count + CNT_W'(1);
  assign last_col  = (lvl == n_m1);
  assign busy      = (state != S_IDLE);

  always_comb begin
    for (int c = 0; c < MAX_QUEENS; c++) begin
      packed_rows[c*ROW_W +: ROW_W] = (SIZE_W'(c) < n) ? rows[c] : '0;
    end
  end

  nq_attack_unit u_attack (
    .lvl   (lvl),
    .col   (col),
    .cand  (row[ROW_W-1:0]),
    .other (rd),
    .hit   (hit)
  );

  always_ff @(posedge clk) begin
    res_valid <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int c = 0; c < MAX_QUEENS; c++) begin
        rows[c] <= '0;
      end
      lvl   <= '0;
      col   <= '0;
      adv   <= 1'b0;
      sdone <= 1'b0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (go) begin
            if (restart) begin
              for (int c = 0; c < MAX_QUEENS; c++) begin
                rows[c] <= '0;
              end
              lvl   <= '0;
              adv   <= 1'b0;
              count <= '0;
              sdone <= 1'b0;
              state <= S_LOAD;
            end else if (sdone) begin
              res       <= '{found: 1'b0, placement: '0, count: count};
              res_valid <= 1'b1;
            end else begin
              if (lvl > n_m1) begin
                lvl <= n_m1;
              end
              adv   <= (count != '0);
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          row   <= {1'b0, rd} + {{(SIZE_W-1){1'b0}}, adv};
          adv   <= 1'b0;
          state <= S_TEST;
        end
        S_TEST: begin
          if (row >= n) begin
            // Column exhausted: clear it and back up one column, or end the search at column zero.
            rows[lvl] <= '0;
            if (lvl == '0) begin
              sdone     <= 1'b1;
              res       <= '{found: 1'b0, placement: '0, count: count};
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              lvl   <= lvl - LVL_W'(1);
              adv   <= 1'b1;
              state <= S_LOAD;
            end
          end else begin
            rows[lvl] <= row[ROW_W-1:0];
            col       <= '0;
            if (lvl != '0) begin
              state <= S_CHECK;
            end else if (last_col) begin
              state <= S_EMIT;
            end else begin
              lvl            <= lvl + LVL_W'(1);
              rows[lvl + 1'b1] <= '0;
              row            <= '0;
              state          <= S_TEST;
            end
          end
        end
        S_CHECK: begin
          if (hit) begin
            adv   <= 1'b1;
            state <= S_LOAD;
          end else if (col == lvl - LVL_W'(1)) begin
            if (last_col) begin
              state <= S_EMIT;
            end else begin
              lvl              <= lvl + LVL_W'(1);
              rows[lvl + 1'b1] <= '0;
              row              <= '0;
              state            <= S_TEST;
            end
          end else begin
            col <= col + LVL_W'(1);
          end
        end
        S_EMIT: begin
          count     <= count_inc;
          res       <= '{found: 1'b1, placement: packed_rows, count: count_inc};
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/n_queens_solution_enumerator_unit.sv @@
// Top level of the N-queens solution enumerator: board size register, request
// handshake and result ports. Depends on nq_pkg and nq_search_seq.
`timescale 1ns / 1ps
// How the block is used:
// A request item is accepted at a rising edge where start is high and busy is
// low. Its restart bit either clears the board and the solution count, or
// continues the search from the last solution found. Busy stays high while the
// backtracking search runs, so only one item is in flight at a time.
// Exactly one result item comes back per request. It is on placement, found
// and solution_count for a single cycle, marked by result_valid; the receiver
// cannot stall, so it must take the item in that cycle.
// A request that meets an exhausted search answers in the cycle right
// after acceptance. Otherwise each row trial passes through the load and test
// states, or the test state only for row zero of a newly entered column, and
// then the check state runs each earlier column through the single shared
// conflict comparator; a found solution adds a packing state before the result.
// The board size register is written through cfg_valid/cfg_data; cfg_ready is
// always high and writes belong in idle periods. Zero acts as one and values
// above sixteen act as sixteen. Reset (rst, synchronous) sets the size to 10,
// clears the board, the count and the exhausted flag, and leaves the block
// idle; no clearing pass is needed.
module n_queens_solution_enumerator_unit import nq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               restart,
  output logic               result_valid,
  output logic [PLACE_W-1:0] placement,
  output logic               found,
  output logic [CNT_W-1:0]   solution_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SIZE_W-1:0]  cfg_data
);

  size_t board_size;
  size_t n;
  res_t  res;
  logic  go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_size <= BOARD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      board_size <= cfg_data;
    end
  end

  // The clamped size is what the sequencer compares rows and columns against.
  assign n  = eff_size(board_size);
  assign go = start && !busy;

  nq_search_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .restart   (restart),
    .n         (n),
    .busy      (busy),
    .res       (res),
    .res_valid (result_valid)
  );

  assign placement      = res.placement;
  assign found          = res.found;
  assign solution_count = res.count;

endmodule

@@ dv/nq_solution_checker.sv @@
// Checker for the N-queens solution enumerator: follows the request, result and
// board size channels, works out each answer itself and compares it.
// Depends on nq_pkg for the result type, the widths and the reset board size.
`timescale 1ns / 1ps
module nq_solution_checker import nq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               restart,
  input  logic               result_valid,
  input  logic [PLACE_W-1:0] placement,
  input  logic               found,
  input  logic [CNT_W-1:0]   solution_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [SIZE_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 in_flight
);

  // Our own copy of the search state and of the board size register.
  row_t             board_rows [MAX_QUEENS];
  logic [4:0]       cur_col;
  logic [CNT_W-1:0] tally;
  logic             exhausted;
  size_t            size_reg;

  res_t solutions_due [$];
  int   errors;

  function automatic void clear_board();
    foreach (board_rows[i]) board_rows[i] = '0;
    cur_col   = '0;
    tally     = '0;
    exhausted = 1'b0;
  endfunction

  // True when a queen in an earlier column shares the row or a diagonal.
  function automatic bit under_attack(input int col, input int row);
    int other;
    int col_gap;
    for (int j = 0; j < col; j++) begin
      other   = int'(board_rows[j]);
      col_gap = col - j;
      if (other == row || other + col_gap == row || row + col_gap == other) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Depth-first walk to the next full placement. A nonzero tally means the
  // board in hand was already reported, so the last column steps on first.
  function automatic bit advance_search(input int n);
    int col;
    int row;
    bit bump;
    col  = int'(cur_col);
    bump = (tally != '0);
    if (col >= n) col = n - 1;
    while (1) begin
      row = int'(board_rows[col]);
      if (bump) begin
        row++;
        bump = 1'b0;
      end
      if (row >= n) begin
        board_rows[col] = '0;
        if (col == 0) begin
          cur_col = '0;
          return 1'b0;
        end
        col--;
        bump = 1'b1;
      end else begin
        board_rows[col] = row_t'(row);
        if (under_attack(col, row)) begin
          bump = 1'b1;
        end else if (col == n - 1) begin
          cur_col = 5'(col);
          return 1'b1;
        end else begin
          col++;
          board_rows[col] = '0;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t answer_request(input logic rs);
    res_t r;
    int   n;
    int   c;
    bit   hit;
    r   = '0;
    hit = 1'b0;
    n   = int'(size_reg);
    if (n < 1) n = 1;
    if (n > MAX_QUEENS) n = MAX_QUEENS;
    if (rs) clear_board();
    if (!exhausted) begin
      hit = advance_search(n);
      if (hit) begin
        if (tally != COUNT_MAX) tally++;
        for (c = 0; c < n; c++) r.placement[ROW_W*c +: ROW_W] = board_rows[c];
      end else begin
        exhausted = 1'b1;
      end
    end
    r.found = hit;
    r.count = tally;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      clear_board();
      size_reg = BOARD_RESET;
      solutions_due.delete();
    end else begin
      // A result leaving now belongs to an item accepted earlier, so it is
      // matched before any item accepted at this same edge is queued.
      if (result_valid) begin
        if (solutions_due.size() == 0) begin
          $display("%0t: result with nothing expected (found %b, count %0d)",
                   $time, found, solution_count);
          errors++;
        end else begin
          want = solutions_due.pop_front();
          if (placement !== want.placement) begin
            $display("%0t: placement expected %h, got %h", $time, want.placement, placement);
            errors++;
          end
          if (found !== want.found) begin
            $display("%0t: found expected %b, got %b", $time, want.found, found);
            errors++;
          end
          if (solution_count !== want.count) begin
            $display("%0t: solution_count expected %0d, got %0d",
                     $time, want.count, solution_count);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (start && !busy) solutions_due.push_back(answer_request(restart));
    end
    fail_count <= errors;
    in_flight  <= solutions_due.size();
  end

endmodule

@@ dv/tb_n_queens_solution_enumerator_unit.sv @@
// Testbench top for the N-queens solution enumerator: clock, reset, request
// and board size stimulus, watchdog and verdict.
// Depends on nq_pkg, n_queens_solution_enumerator_unit and nq_solution_checker.
`timescale 1ns / 1ps
module tb_n_queens_solution_enumerator_unit import nq_pkg::*; ();

  // Longest stretch without any handshake before the run is declared hung.
  // A restart on the sixteen-queen board is by far the slowest item; this
  // leaves that search several times its expected length.
  localparam int STALL_LIMIT  = 12_000_000;
  localparam int RANDOM_ITEMS = 500;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               restart = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [SIZE_W-1:0]  cfg_data = '0;
  logic               busy;
  logic               result_valid;
  logic [PLACE_W-1:0] placement;
  logic               found;
  logic [CNT_W-1:0]   solution_count;
  logic               cfg_ready;
  int                 fail_count;
  int                 outstanding;

  int random_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  n_queens_solution_enumerator_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .restart        (restart),
    .result_valid   (result_valid),
    .placement      (placement),
    .found          (found),
    .solution_count (solution_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // The checker sees the same pins as the block and reports its failure count
  // and the number of answers still owed back to this module.
  nq_solution_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .restart        (restart),
    .result_valid   (result_valid),
    .placement      (placement),
    .found          (found),
    .solution_count (solution_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .in_flight      (outstanding)
  );

  // Drops start so no further item is taken, then waits until every answer
  // has come back and the block has dropped busy.
  // The first edge is always taken because the checker's count only moves
  // after the edge at which an item was accepted.
  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One write of the board size register; only called while the block is idle.
  task automatic write_board_size(input size_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one request item. A nonzero gap drops start first, for a span set by
  // gap; drain additionally holds off until every answer is back. With no gap and
  // no drain, start simply stays high so that back-to-back items meet busy.
  task automatic issue_request(input logic rs, input int gap, input bit drain);
    if (gap > 0 || drain) begin
      start <= 1'b0;
      repeat ((gap > 0) ? gap : 1) @(posedge clk);
      while (drain && outstanding != 0) @(posedge clk);
    end
    start   <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Watchdog: any handshake on any channel counts as progress.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int    pick;
    int    span;
    bit    steady;
    bit    keep;
    size_t board;
    logic  rs;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    // Reset board of ten: a continue right after reset must behave like a
    // fresh search, then one more continue, then a restart back to the start.
    issue_request(1'b0, 0, 1'b0);
    issue_request(1'b0, $urandom_range(0, 7), 1'b0);
    issue_request(1'b1, 0, 1'b1);

    // Single square: one solution, then the exhausted answer twice in a row.
    wait_quiet();
    write_board_size(size_t'(1));
    issue_request(1'b1, 0, 1'b0);
    issue_request(1'b0, 0, 1'b0);
    issue_request(1'b0, $urandom_range(0, 7), 1'b0);

    // A size of zero must act as one.
    wait_quiet();
    write_board_size(size_t'(0));
    issue_request(1'b1, 0, 1'b0);

    // Boards of two and three have no solution at all.
    wait_quiet();
    write_board_size(size_t'(2));
    issue_request(1'b1, 0, 1'b0);
    wait_quiet();
    write_board_size(size_t'(3));
    issue_request(1'b1, 0, 1'b0);

    // Four queens: both solutions, then exhaustion.
    wait_quiet();
    write_board_size(size_t'(4));
    issue_request(1'b1, 0, 1'b0);
    issue_request(1'b0, 0, 1'b0);
    issue_request(1'b0, 0, 1'b0);

    // Size changed in the middle of a search: shrink from six to five and then
    // grow to eight without a restart, so stored rows go out of range.
    wait_quiet();
    write_board_size(size_t'(6));
    issue_request(1'b1, 0, 1'b0);
    issue_request(1'b0, 0, 1'b0);
    wait_quiet();
    write_board_size(size_t'(5));
    issue_request(1'b0, 0, 1'b0);
    issue_request(1'b0, 0, 1'b0);
    wait_quiet();
    write_board_size(size_t'(8));
    issue_request(1'b0, 0, 1'b0);

    // Largest board, once from scratch since it is slow, then sizes above
    // sixteen that must clamp to it while the search goes on.
    wait_quiet();
    write_board_size(size_t'(MAX_QUEENS));
    issue_request(1'b1, 0, 1'b0);
    issue_request(1'b0, 0, 1'b0);
    wait_quiet();
    write_board_size(size_t'(31));
    issue_request(1'b0, 0, 1'b0);
    wait_quiet();
    write_board_size(size_t'(17));
    issue_request(1'b0, 0, 1'b0);

    // Random part: phases of one board size each. Most phases restart and then
    // walk on through the solutions, often to exhaustion on small boards; some
    // change the size mid-search, which is kept to boards of eight or fewer so
    // that the stale-state search stays short.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        board = size_t'($urandom_range(0, 3));
      end else if (pick < 86) begin
        board = size_t'($urandom_range(4, 8));
      end else if (pick < 96) begin
        board = size_t'($urandom_range(9, 10));
      end else begin
        board = size_t'($urandom_range(11, 12));
      end
      keep   = (board <= size_t'(8)) && ($urandom_range(0, 3) == 0);
      span   = $urandom_range(3, 60);
      steady = ($urandom_range(0, 2) == 0);
      wait_quiet();
      write_board_size(board);
      for (int k = 0; k < span; k++) begin
        rs = (k == 0 && !keep) || ($urandom_range(0, 15) == 0);
        issue_request(rs, steady ? 0 : int'($urandom_range(0, 7)),
                      $urandom_range(0, 9) == 0);
        random_sent++;
      end
    end

    wait_quiet();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/nq_pkg.sv
design/nq_attack_unit.sv
design/nq_search_seq.sv
design/n_queens_solution_enumerator_unit.sv
dv/nq_solution_checker.sv
dv/tb_n_queens_solution_enumerator_unit.sv
